>>> rtl/strc_pkg.sv
// Package for the sorted-table record checker: phase and code enums, widths, constants.
// No dependencies; every rtl module imports it.
package strc_pkg;

   localparam int unsigned KeyStoreBytes = 256;
   localparam int unsigned KeyAddrW      = $clog2(KeyStoreBytes);

   localparam logic [31:0] FnvOffset     = 32'd2166136261;
   localparam logic [31:0] FnvPrime      = 32'd16777619;
   localparam logic [24:0] MaxFieldReset = 25'd16777216;
   localparam logic [31:0] MagicReset    = 32'd826426449;

   typedef enum logic [3:0] {
      PH_MAGIC = 4'd0,
      PH_KLEN  = 4'd1,
      PH_VLEN  = 4'd2,
      PH_TIME  = 4'd3,
      PH_TOMB  = 4'd4,
      PH_KEY   = 4'd5,
      PH_VAL   = 4'd6,
      PH_CRC   = 4'd7,
      PH_HALT  = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ORD_EQ = 2'd0,
      ORD_GT = 2'd1,
      ORD_LT = 2'd2
   } order_type;

   typedef enum logic [2:0] {
      KIND_KEY    = 3'd0,
      KIND_VALUE  = 3'd1,
      KIND_RECORD = 3'd2,
      KIND_OK     = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_MAGIC     = 3'd1,
      ERR_LENGTH    = 3'd2,
      ERR_TOMBSTONE = 3'd3,
      ERR_CHECKSUM  = 3'd4,
      ERR_ORDER     = 3'd5,
      ERR_TRUNCATED = 3'd6,
      ERR_KEY_LONG  = 3'd7
   } error_type;

   typedef enum logic [0:0] {
      CSR_MAX_FIELD = 1'd0,
      CSR_MAGIC     = 1'd1
   } csr_index_type;

   // Result beat handed from the parser to the output stage.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      error_type   error_code;
      logic [24:0] key_length;
      logic [24:0] value_length;
      logic [63:0] record_time;
      logic        deleted_mark;
   } result_type;

   // Key-store access from the parser: a read for the compare and a write
   // of the new key byte at the same index.
   typedef struct packed {
      logic                rd_en;
      logic [KeyAddrW-1:0] rd_addr;
      logic                wr_en;
      logic [KeyAddrW-1:0] wr_addr;
      logic [7:0]          wr_data;
   } store_req_type;

endpackage

>>> rtl/strc_key_store.sv
// Previous-key byte store: synchronous RAM with one write and one registered read port.
// Depends on strc_pkg.
module strc_key_store (
   input  logic                   clock,
   input  strc_pkg::store_req_type req,
   output logic [7:0]             rd_data
);
   import strc_pkg::*;

   logic [7:0] mem [KeyStoreBytes];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/strc_out_stage.sv
// Two-entry skid buffer on the result channel so the parser never waits on a stall.
// Depends on strc_pkg.
module strc_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  strc_pkg::result_type in_data,
   output logic                in_stall,
   output logic                out_valid,
   input  logic                out_stall,
   output strc_pkg::result_type out_data
);
   import strc_pkg::*;

   result_type main_ff, skid_ff;
   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       take, give;

   // The producer's result register cannot hold, so the stall looks ahead: a beat
   // accepted now must find the skid entry free at the next edge.
   assign in_stall  = skid_valid_in;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign take      = in_valid && !skid_valid_ff;
   assign give      = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (give) begin
         main_valid_in = skid_valid_ff || take;
         skid_valid_in = 1'b0;
      end else if (take) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (give) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (take && !main_valid_ff) begin
         main_ff <= in_data;
      end
      if (take && main_valid_ff && !give) begin
         skid_ff <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff) else $error("skid full while main empty");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid && $stable(out_data))
      else $error("result changed under stall");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !give |=> skid_valid_ff) else $error("skid lost");
`endif

endmodule

>>> rtl/strc_parser.sv
// Byte parser: phase sequencer, FNV-1a checksum, field capture and on-the-fly key compare.
// Depends on strc_pkg; talks to strc_key_store through a store_req_type struct.
module strc_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_stream,
   input  logic [24:0]            max_field_size,
   input  logic [31:0]            magic_word,
   output strc_pkg::store_req_type store_req,
   input  logic [7:0]             store_rd_data,
   output logic                   res_valid,
   output strc_pkg::result_type   res_data
);
   import strc_pkg::*;

   // Stage 1 registers: parser state.
   phase_type   phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] shift_ff, shift_in;
   logic [24:0] klen_ff, klen_in, vlen_ff, vlen_in, left_ff, left_in;
   logic [63:0] time_ff, time_in;
   logic        del_ff, del_in;
   logic [31:0] csum_ff, csum_in;
   order_type   ord_ff, ord_in;
   logic [24:0] plen_ff, plen_in;
   logic        have_ff, have_in;
   logic        res_valid_ff, res_valid_in;
   result_type  res_ff, res_in;

   // Key compare is deferred to the next cycle, when the store read returns.
   logic        cmp_ff, cmp_in;
   logic [7:0]  cmp_byte_ff;
   // Checksum multiply pipelined: xor value held, product taken next cycle.
   logic [31:0] mix_ff;
   logic        mix_pend_ff, mix_pend_in;

   logic [63:0] shift_or;
   logic [24:0] kidx;
   logic [31:0] csum_now;
   order_type   ord_now;
   logic [24:0] field25;
   logic        field_big;

   // Resolve pending multiply and pending compare as the current view.
   always_comb begin
      csum_now = mix_pend_ff ? 32'(mix_ff * FnvPrime) : csum_ff;
      ord_now  = ord_ff;
      if (cmp_ff && ord_ff == ORD_EQ) begin
         if (cmp_byte_ff > store_rd_data) begin
            ord_now = ORD_GT;
         end else if (cmp_byte_ff < store_rd_data) begin
            ord_now = ORD_LT;
         end
      end
   end

   assign shift_or  = shift_ff | (64'(data_byte) << {idx_ff, 3'b000});
   assign kidx      = klen_ff - left_ff;
   assign field25   = shift_or[24:0];
   assign field_big = (shift_or[31:25] != 7'd0);

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      shift_in     = shift_ff;
      klen_in      = klen_ff;
      vlen_in      = vlen_ff;
      left_in      = left_ff;
      time_in      = time_ff;
      del_in       = del_ff;
      csum_in      = csum_now;
      ord_in       = ord_now;
      plen_in      = plen_ff;
      have_in      = have_ff;
      cmp_in       = 1'b0;
      mix_pend_in  = 1'b0;
      res_valid_in = 1'b0;
      res_in       = '0;
      store_req    = '0;
      store_req.wr_data = data_byte;
      store_req.wr_addr = kidx[KeyAddrW-1:0];
      store_req.rd_addr = kidx[KeyAddrW-1:0];

      if (beat && phase_ff != PH_HALT) begin
         if (end_of_stream) begin
            res_valid_in = 1'b1;
            phase_in     = PH_HALT;
            if (phase_ff == PH_MAGIC) begin
               res_in.kind = KIND_ERROR; res_in.error_code = ERR_MAGIC;
            end else if (phase_ff == PH_KLEN && idx_ff == 3'd0) begin
               res_in.kind = KIND_OK;
            end else begin
               res_in.kind = KIND_ERROR; res_in.error_code = ERR_TRUNCATED;
            end
         end else begin
            unique case (phase_ff)
               PH_MAGIC: begin
                  if (data_byte != magic_word[{idx_ff[1:0], 3'b000} +: 8]) begin
                     res_valid_in = 1'b1; phase_in = PH_HALT;
                     res_in.kind = KIND_ERROR; res_in.error_code = ERR_MAGIC;
                  end else if (idx_ff == 3'd3) begin
                     phase_in = PH_KLEN; idx_in = '0; shift_in = '0;
                     csum_in = FnvOffset; ord_in = ORD_EQ;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end
               PH_KLEN, PH_VLEN, PH_TIME, PH_CRC: begin
                  if (phase_ff != PH_CRC) begin
                     mix_pend_in = 1'b1;
                  end
                  shift_in = shift_or;
                  idx_in   = idx_ff + 3'd1;
                  if (phase_ff == PH_TIME) begin
                     if (idx_ff == 3'd7) begin
                        time_in = shift_or; phase_in = PH_TOMB;
                        idx_in = '0; shift_in = '0;
                     end
                  end else if (idx_ff == 3'd3) begin
                     idx_in = '0; shift_in = '0;
                     if (phase_ff == PH_KLEN) begin
                        if (field_big || field25 > max_field_size) begin
                           res_valid_in = 1'b1; phase_in = PH_HALT;
                           res_in.kind = KIND_ERROR; res_in.error_code = ERR_LENGTH;
                        end else if (field25 > 25'(KeyStoreBytes)) begin
                           res_valid_in = 1'b1; phase_in = PH_HALT;
                           res_in.kind = KIND_ERROR; res_in.error_code = ERR_KEY_LONG;
                        end else begin
                           klen_in = field25; phase_in = PH_VLEN;
                        end
                     end else if (phase_ff == PH_VLEN) begin
                        if (field_big || field25 > max_field_size) begin
                           res_valid_in = 1'b1; phase_in = PH_HALT;
                           res_in.kind = KIND_ERROR; res_in.error_code = ERR_LENGTH;
                        end else begin
                           vlen_in = field25; phase_in = PH_TIME;
                        end
                     end else begin
                        res_valid_in = 1'b1;
                        if (shift_or[31:0] != csum_now) begin
                           phase_in = PH_HALT;
                           res_in.kind = KIND_ERROR; res_in.error_code = ERR_CHECKSUM;
                        end else if (have_ff && ord_now != ORD_GT) begin
                           phase_in = PH_HALT;
                           res_in.kind = KIND_ERROR; res_in.error_code = ERR_ORDER;
                        end else begin
                           res_in.kind         = KIND_RECORD;
                           res_in.key_length   = klen_ff;
                           res_in.value_length = vlen_ff;
                           res_in.record_time  = time_ff;
                           res_in.deleted_mark = del_ff;
                           plen_in = klen_ff; have_in = 1'b1;
                           phase_in = PH_KLEN; csum_in = FnvOffset; ord_in = ORD_EQ;
                        end
                     end
                  end
               end
               PH_TOMB: begin
                  if (data_byte > 8'd1) begin
                     res_valid_in = 1'b1; phase_in = PH_HALT;
                     res_in.kind = KIND_ERROR; res_in.error_code = ERR_TOMBSTONE;
                  end else begin
                     mix_pend_in = 1'b1;
                     del_in = data_byte[0]; ord_in = ORD_EQ;
                     if (klen_ff != '0) begin
                        phase_in = PH_KEY; left_in = klen_ff;
                     end else if (vlen_ff != '0) begin
                        phase_in = PH_VAL; left_in = vlen_ff;
                     end else begin
                        phase_in = PH_CRC; idx_in = '0; shift_in = '0;
                     end
                  end
               end
               PH_KEY: begin
                  mix_pend_in = 1'b1;
                  // Key length never exceeds the store, so every index is in range.
                  store_req.wr_en = 1'b1;
                  if (ord_now == ORD_EQ && have_ff) begin
                     if (kidx < plen_ff) begin
                        store_req.rd_en = 1'b1; cmp_in = 1'b1;
                     end else begin
                        ord_in = ORD_GT;
                     end
                  end
                  left_in = left_ff - 25'd1;
                  if (left_ff == 25'd1) begin
                     if (vlen_ff != '0) begin
                        phase_in = PH_VAL; left_in = vlen_ff;
                     end else begin
                        phase_in = PH_CRC; idx_in = '0; shift_in = '0;
                     end
                  end
                  res_valid_in = 1'b1;
                  res_in.kind = KIND_KEY; res_in.payload_byte = data_byte;
               end
               PH_VAL: begin
                  mix_pend_in = 1'b1;
                  left_in = left_ff - 25'd1;
                  if (left_ff == 25'd1) begin
                     phase_in = PH_CRC; idx_in = '0; shift_in = '0;
                  end
                  res_valid_in = 1'b1;
                  res_in.kind = KIND_VALUE; res_in.payload_byte = data_byte;
               end
               default: phase_in = PH_HALT;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         idx_ff       <= '0;
         shift_ff     <= '0;
         klen_ff      <= '0;
         vlen_ff      <= '0;
         left_ff      <= '0;
         time_ff      <= '0;
         del_ff       <= 1'b0;
         csum_ff      <= FnvOffset;
         ord_ff       <= ORD_EQ;
         plen_ff      <= '0;
         have_ff      <= 1'b0;
         cmp_ff       <= 1'b0;
         mix_pend_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         shift_ff     <= shift_in;
         klen_ff      <= klen_in;
         vlen_ff      <= vlen_in;
         left_ff      <= left_in;
         time_ff      <= time_in;
         del_ff       <= del_in;
         csum_ff      <= csum_in;
         ord_ff       <= ord_in;
         plen_ff      <= plen_in;
         have_ff      <= have_in;
         cmp_ff       <= cmp_in;
         mix_pend_ff  <= mix_pend_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      cmp_byte_ff <= data_byte;
      mix_ff      <= csum_now ^ {24'd0, data_byte};
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;

`ifndef SYNTHESIS
   a_key_fits: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_KEY |-> klen_ff <= 25'(KeyStoreBytes) && left_ff != '0)
      else $error("key index out of store");
   a_cmp_only_in_key: assert property (@(posedge clock) disable iff (reset)
      cmp_ff |-> $past(phase_ff) == PH_KEY) else $error("stray key compare");
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT && !res_valid_ff)
      else $error("left halt");
`endif

endmodule

>>> rtl/sorted_table_record_checker_top.sv
// Top level of the sorted-table record checker: CSRs, parser, key store, result skid stage.
// Depends on strc_pkg, strc_parser, strc_key_store and strc_out_stage.
//
// Usage: the req_ channel carries one file byte per beat (req_data_byte), or an
// end marker (req_end_of_stream). A beat is taken when req_valid is high and
// req_stall is low. Each beat gives zero or one result beat on the rsp_ channel:
// key or value bytes as they pass, a verified-record beat with its header fields
// at the stored checksum's last byte, a stream-ok beat on a clean end, or an
// error beat, after which the block stays halted until reset.
// A result beat reaches rsp_valid through the parser's result register and then the
// output skid. Throughput is one byte per cycle while req_stall is low; the FNV
// xor is registered and its multiply done after that register, with the product
// forwarded into the next byte, and the compare completes where the registered
// previous-key RAM read lands. A two-entry output skid lets input flow while
// a result is stalled; req_stall rises when the next edge would fill the second
// entry, so the result of every accepted beat always finds room.
// Synchronous reset returns to magic search and restores CSR defaults; the key
// RAM is not cleared and needs no clearing pass. CSRs (index 0 max field size,
// index 1 magic) are written on csr_valid, always ready.
module sorted_table_record_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_error_code,
   output logic [24:0] rsp_key_length,
   output logic [24:0] rsp_value_length,
   output logic [63:0] rsp_record_time,
   output logic        rsp_deleted_mark,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import strc_pkg::*;

   logic [24:0]   max_field_ff;
   logic [31:0]   magic_ff;
   logic          beat;
   store_req_type store_req;
   logic [7:0]    store_rd_data;
   logic          res_valid;
   result_type    res_data, out_data;
   logic          skid_stall;

   assign csr_ready = 1'b1;
   assign beat      = req_valid && !req_stall;
   assign req_stall = skid_stall;

   // CSR writes; index decoded by name.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_field_ff <= MaxFieldReset;
         magic_ff     <= MagicReset;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_FIELD: max_field_ff <= csr_data[24:0];
            CSR_MAGIC:     magic_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   strc_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .beat           (beat),
      .data_byte      (req_data_byte),
      .end_of_stream  (req_end_of_stream),
      .max_field_size (max_field_ff),
      .magic_word     (magic_ff),
      .store_req      (store_req),
      .store_rd_data  (store_rd_data),
      .res_valid      (res_valid),
      .res_data       (res_data)
   );

   strc_key_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (store_rd_data)
   );

   strc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_stall  (skid_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_error_code   = out_data.error_code;
   assign rsp_key_length   = out_data.key_length;
   assign rsp_value_length = out_data.value_length;
   assign rsp_record_time  = out_data.record_time;
   assign rsp_deleted_mark = out_data.deleted_mark;

`ifndef SYNTHESIS
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid) else $error("input stalled with no result held");
   a_csr_applied: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == CSR_MAGIC |=> magic_ff == $past(csr_data))
      else $error("magic write lost");
   a_result_follows_beat: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> $past(beat)) else $error("result without input beat");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for sorted_table_record_checker_top: streams of records
// with a bit-accurate predictor, randomized idling on both channels and CSR phases.
// Depends on strc_pkg and the RTL top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import strc_pkg::*;

   typedef logic [7:0] byte_list_type[$];
   typedef struct {
      logic [7:0] data;
      logic       eos;
   } file_beat_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_error_code;
   logic [24:0] rsp_key_length;
   logic [24:0] rsp_value_length;
   logic [63:0] rsp_record_time;
   logic        rsp_deleted_mark;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = 32'd0;

   sorted_table_record_checker_top dut (.*);

   // File bytes waiting to be sent, and result beats the predictor expects.
   file_beat_type pending_beats[$];
   result_type    expected_results[$];
   file_beat_type next_beat;
   int            mismatches = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;

   // Predictor state, kept in step with the block as input beats are accepted.
   logic [24:0] cfg_max_field;
   logic [31:0] cfg_magic;
   phase_type   ph;
   int unsigned field_idx;
   logic [63:0] field_acc;
   logic [24:0] rec_key_len;
   logic [24:0] rec_value_len;
   logic [63:0] rec_time;
   logic        rec_deleted;
   logic [24:0] remaining;
   logic [31:0] fnv_sum;
   order_type   key_order;
   logic [7:0]  last_key[KeyStoreBytes];
   logic [24:0] last_key_len;
   logic        have_last_key;

   // Stimulus side: the last good key that was generated, for strict ordering.
   byte_list_type gen_key;
   bit            gen_have_key;
   logic [31:0]   gen_magic;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("tb: failure");
      $finish;
   end

   function automatic void push_result(kind_type k, logic [7:0] pay, error_type e,
                                       logic [24:0] kl, logic [24:0] vl,
                                       logic [63:0] t, logic del);
      result_type r;
      r.kind = k;
      r.payload_byte = pay;
      r.error_code = e;
      r.key_length = kl;
      r.value_length = vl;
      r.record_time = t;
      r.deleted_mark = del;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void push_error(error_type e);
      ph = PH_HALT;
      push_result(KIND_ERROR, 8'd0, e, '0, '0, '0, 1'b0);
   endfunction

   function automatic void mix_byte(logic [7:0] b);
      fnv_sum = (fnv_sum ^ {24'd0, b}) * FnvPrime;
   endfunction

   function automatic void begin_record();
      ph = PH_KLEN;
      field_idx = 0;
      field_acc = '0;
      fnv_sum = FnvOffset;
      key_order = ORD_EQ;
   endfunction

   function automatic void key_done();
      if (rec_value_len > 0) begin
         ph = PH_VAL;
         remaining = rec_value_len;
      end else begin
         ph = PH_CRC;
         field_idx = 0;
         field_acc = '0;
      end
   endfunction

   function automatic void reset_predictor();
      cfg_max_field = MaxFieldReset;
      cfg_magic = MagicReset;
      ph = PH_MAGIC;
      field_idx = 0;
      field_acc = '0;
      rec_key_len = '0;
      rec_value_len = '0;
      rec_time = '0;
      rec_deleted = 1'b0;
      remaining = '0;
      fnv_sum = FnvOffset;
      key_order = ORD_EQ;
      last_key_len = '0;
      have_last_key = 1'b0;
   endfunction

   // Works out the result, if any, of one accepted input beat.
   function automatic void predict_beat(logic [7:0] b, logic eos);
      int unsigned pos;
      if (ph == PH_HALT) return;
      if (eos) begin
         if (ph == PH_MAGIC) push_error(ERR_MAGIC);
         else if (ph == PH_KLEN && field_idx == 0) begin
            ph = PH_HALT;
            push_result(KIND_OK, 8'd0, ERR_NONE, '0, '0, '0, 1'b0);
         end else push_error(ERR_TRUNCATED);
         return;
      end
      case (ph)
         PH_MAGIC: begin
            if (b != cfg_magic[8*field_idx +: 8]) begin
               push_error(ERR_MAGIC);
               return;
            end
            field_idx++;
            if (field_idx == 4) begin_record();
         end
         PH_KLEN, PH_VLEN, PH_TIME, PH_CRC: begin
            if (ph != PH_CRC) mix_byte(b);
            field_acc |= 64'(b) << (8 * (field_idx & 7));
            field_idx++;
            if (ph == PH_TIME) begin
               if (field_idx == 8) begin
                  rec_time = field_acc;
                  ph = PH_TOMB;
                  field_idx = 0;
                  field_acc = '0;
               end
               return;
            end
            if (field_idx < 4) return;
            if (ph == PH_KLEN) begin
               if (field_acc > 64'(cfg_max_field)) begin
                  push_error(ERR_LENGTH);
                  return;
               end
               if (field_acc > 64'(KeyStoreBytes)) begin
                  push_error(ERR_KEY_LONG);
                  return;
               end
               rec_key_len = field_acc[24:0];
               ph = PH_VLEN;
            end else if (ph == PH_VLEN) begin
               if (field_acc > 64'(cfg_max_field)) begin
                  push_error(ERR_LENGTH);
                  return;
               end
               rec_value_len = field_acc[24:0];
               ph = PH_TIME;
            end else begin
               if (field_acc[31:0] != fnv_sum) begin
                  push_error(ERR_CHECKSUM);
                  return;
               end
               if (have_last_key && key_order != ORD_GT) begin
                  push_error(ERR_ORDER);
                  return;
               end
               push_result(KIND_RECORD, 8'd0, ERR_NONE, rec_key_len, rec_value_len,
                           rec_time, rec_deleted);
               last_key_len = rec_key_len;
               have_last_key = 1'b1;
               begin_record();
               return;
            end
            field_idx = 0;
            field_acc = '0;
         end
         PH_TOMB: begin
            if (b > 8'd1) begin
               push_error(ERR_TOMBSTONE);
               return;
            end
            mix_byte(b);
            rec_deleted = b[0];
            key_order = ORD_EQ;
            if (rec_key_len > 0) begin
               ph = PH_KEY;
               remaining = rec_key_len;
            end else key_done();
         end
         PH_KEY: begin
            pos = rec_key_len - remaining;
            mix_byte(b);
            if (pos < KeyStoreBytes) begin
               // The key is ordered on the fly: the first differing byte decides,
               // and running past the end of the previous key makes this one greater.
               if (key_order == ORD_EQ && have_last_key) begin
                  if (pos < last_key_len) begin
                     if (b > last_key[pos]) key_order = ORD_GT;
                     else if (b < last_key[pos]) key_order = ORD_LT;
                  end else key_order = ORD_GT;
               end
               last_key[pos] = b;
            end
            remaining--;
            if (remaining == 0) key_done();
            push_result(KIND_KEY, b, ERR_NONE, '0, '0, '0, 1'b0);
         end
         PH_VAL: begin
            mix_byte(b);
            remaining--;
            if (remaining == 0) begin
               ph = PH_CRC;
               field_idx = 0;
               field_acc = '0;
            end
            push_result(KIND_VALUE, b, ERR_NONE, '0, '0, '0, 1'b0);
         end
         default: ph = PH_HALT;
      endcase
   endfunction

   // Driver: a beat that is stalled holds; otherwise the next pending byte may
   // go out, unless the sender decides to idle this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_beat(req_data_byte, req_end_of_stream);
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_beat.data;
               req_end_of_stream <= next_beat.eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("tb: mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
      mismatches++;
   endtask

   // Monitor: every accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat kind", 64'(rsp_kind), 64'd0);
            end else begin
               result_type want;
               want = expected_results.pop_front();
               if (rsp_kind != want.kind)
                  report_mismatch("kind", 64'(rsp_kind), 64'(want.kind));
               if (rsp_payload_byte != want.payload_byte)
                  report_mismatch("payload_byte", 64'(rsp_payload_byte), 64'(want.payload_byte));
               if (rsp_error_code != want.error_code)
                  report_mismatch("error_code", 64'(rsp_error_code), 64'(want.error_code));
               if (rsp_key_length != want.key_length)
                  report_mismatch("key_length", 64'(rsp_key_length), 64'(want.key_length));
               if (rsp_value_length != want.value_length)
                  report_mismatch("value_length", 64'(rsp_value_length),
                                  64'(want.value_length));
               if (rsp_record_time != want.record_time)
                  report_mismatch("record_time", rsp_record_time, want.record_time);
               if (rsp_deleted_mark != want.deleted_mark)
                  report_mismatch("deleted_mark", 64'(rsp_deleted_mark),
                                  64'(want.deleted_mark));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Register writes are issued only while the block is idle, so the predictor
   // can take the new value at the accepting edge.
   task automatic write_register(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_FIELD) cfg_max_field = value[24:0];
      else cfg_magic = value;
      csr_valid <= 1'b0;
   endtask

   // Waits until every byte has gone out and every result has come back, then
   // lets the pipeline drain for bytes that produce no result.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_beats.size() > 0 || req_valid || expected_results.size() > 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_byte(logic [7:0] b, logic eos);
      file_beat_type fb;
      fb.data = b;
      fb.eos = eos;
      pending_beats.insert(pending_beats.size(), fb);
   endtask

   function automatic byte_list_type random_bytes(int n);
      byte_list_type q;
      repeat (n) q.insert(q.size(), 8'($urandom_range(255)));
      return q;
   endfunction

   // Builds a key strictly greater than the last good one: a short common prefix,
   // then a larger byte (or an extension), padded with random bytes.
   function automatic byte_list_type next_key(int min_len);
      byte_list_type k;
      int p;
      if (gen_have_key) begin
         p = $urandom_range(0, (gen_key.size() < 4) ? gen_key.size() : 4);
         while (p < gen_key.size() && gen_key[p] == 8'hFF) p++;
         for (int i = 0; i < p; i++) k.insert(k.size(), gen_key[i]);
         if (p < gen_key.size())
            k.insert(k.size(), 8'($urandom_range(gen_key[p] + 1, 255)));
         else k.insert(k.size(), 8'($urandom_range(255)));
      end
      while (k.size() < min_len) k.insert(k.size(), 8'($urandom_range(255)));
      gen_key = k;
      gen_have_key = 1'b1;
      return k;
   endfunction

   // Queues one record with its checksum. A nonzero flip corrupts the stored
   // checksum; a positive cut sends only that many bytes and then the end marker.
   task automatic add_record(byte_list_type key_bytes, byte_list_type value_bytes,
                             logic [31:0] key_len_field, logic [63:0] stamp,
                             logic [7:0] tomb, logic [31:0] flip, int cut);
      byte_list_type rec;
      logic [31:0] sum;
      logic [31:0] vlen;
      vlen = value_bytes.size();
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), key_len_field[8*i +: 8]);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), vlen[8*i +: 8]);
      for (int i = 0; i < 8; i++) rec.insert(rec.size(), stamp[8*i +: 8]);
      rec.insert(rec.size(), tomb);
      foreach (key_bytes[i]) rec.insert(rec.size(), key_bytes[i]);
      foreach (value_bytes[i]) rec.insert(rec.size(), value_bytes[i]);
      sum = FnvOffset;
      foreach (rec[i]) sum = (sum ^ {24'd0, rec[i]}) * FnvPrime;
      sum ^= flip;
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), sum[8*i +: 8]);
      if (cut > 0) begin
         for (int i = 0; i < cut; i++) push_byte(rec[i], 1'b0);
         push_byte(8'($urandom_range(255)), 1'b1);
      end else begin
         foreach (rec[i]) push_byte(rec[i], 1'b0);
      end
   endtask

   task automatic add_random_record();
      byte_list_type k;
      k = next_key($urandom_range(0, 3));
      add_record(k, random_bytes($urandom_range(0, 12)), k.size(),
                 {$urandom, $urandom}, 8'($urandom_range(1)), 32'd0, 0);
   endtask

   initial begin
      byte_list_type k;
      byte_list_type v;
      int finale;
      logic [31:0] flip;
      reset_predictor();
      gen_have_key = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The magic is chosen per run; the extremes come up now and then.
      case ($urandom_range(3))
         0: gen_magic = 32'd0;
         1: gen_magic = 32'hFFFF_FFFF;
         2: gen_magic = MagicReset;
         default: gen_magic = $urandom;
      endcase
      write_register(CSR_MAGIC, gen_magic);
      write_register(CSR_MAX_FIELD, MaxFieldReset);
      for (int i = 0; i < 4; i++) push_byte(gen_magic[8*i +: 8], 1'b0);

      // Directed records: an empty record first, then a key of one zero byte with
      // extreme value bytes, all-ones timestamp and tombstone set, then a key that
      // fills the whole key store, then a longer value.
      k = next_key(0);
      v = {};
      add_record(k, v, 0, 64'd0, 8'd0, 32'd0, 0);
      k = {8'h00};
      gen_key = k;
      v = {8'hFF, 8'h00};
      add_record(k, v, 1, '1, 8'd1, 32'd0, 0);
      k = next_key(KeyStoreBytes);
      v = {};
      add_record(k, v, k.size(), {$urandom, $urandom}, 8'd0, 32'd0, 0);
      k = next_key(1);
      add_record(k, random_bytes(20), k.size(), {$urandom, $urandom}, 8'd1, 32'd0, 0);
      wait_drained();

      // Random phases with different idling and length limits. Each phase ends
      // with the sender holding off until every result is back.
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         case (phase_no)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         write_register(CSR_MAX_FIELD, (phase_no % 2) ? 32'd300 : 32'd24);
         while (pending_beats.size() < 25) add_random_record();
         wait_drained();
      end

      // One stream ends only once per reset, so the way it ends is picked at
      // random: a clean end, or one of the record-level faults.
      finale = $urandom_range(6);
      write_register(CSR_MAX_FIELD, (finale == 4) ? 32'd0 : 32'(MaxFieldReset));
      send_idle_pct = 10;
      stall_pct = 10;
      case (finale)
         0: push_byte(8'($urandom_range(255)), 1'b1);
         1: begin
            // Truncation somewhere inside a record.
            k = next_key(2);
            v = random_bytes(4);
            add_record(k, v, k.size(), {$urandom, $urandom}, 8'd0, 32'd0,
                       $urandom_range(1, 20 + k.size() + v.size()));
         end
         2: begin
            flip = 32'd1 << $urandom_range(31);
            k = next_key(1);
            add_record(k, random_bytes(3), k.size(), {$urandom, $urandom}, 8'd0, flip, 0);
         end
         3: begin
            k = next_key(1);
            add_record(k, random_bytes(2), k.size(), {$urandom, $urandom},
                       8'($urandom_range(2, 255)), 32'd0, 0);
         end
         4: begin
            // With a zero length limit, any key length above zero is rejected.
            k = next_key(1);
            add_record(k, random_bytes(2), k.size(), {$urandom, $urandom}, 8'd0, 32'd0, 0);
         end
         5: begin
            k = random_bytes(KeyStoreBytes + 1);
            add_record(k, random_bytes(1), k.size(), {$urandom, $urandom}, 8'd0, 32'd0, 0);
         end
         default: begin
            // A repeat of the last key is not strictly greater.
            k = gen_key;
            add_record(k, random_bytes(2), k.size(), {$urandom, $urandom}, 8'd0, 32'd0, 0);
         end
      endcase
      // Noise after the end: the halted block must stay silent.
      repeat (20) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/strc_pkg.sv
rtl/strc_key_store.sv
rtl/strc_out_stage.sv
rtl/strc_parser.sv
rtl/sorted_table_record_checker_top.sv
test/testbench.sv
